@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the cache lookup block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define SALC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SALC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// types and constants shared by the set associative lru cache lookup
// ----------------------------------------------------------------------------
package salc_pkg;

	// default sizing
	localparam int DEF_MAX_WAYS   = 8;
	localparam int DEF_MAX_SETS   = 1024;
	localparam int DEF_ADDR_WIDTH = 32;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RST_OFFSET_BITS = 4'd5;
	localparam logic [CFG_DATA_W-1:0] RST_SET_BITS    = 4'd7;
	localparam logic [CFG_DATA_W-1:0] RST_WAYS_IN_USE = 4'd4;

	// clamp limits
	localparam logic [CFG_DATA_W-1:0] OFFSET_MAX   = 4'd8;
	localparam logic [CFG_DATA_W-1:0] SET_BITS_MAX = 4'd10;

	// widths fixed by the field layout
	localparam int RAW_SET_W = 10;  // set index before the modulo, set_bits <= 10
	localparam int SHIFT_W   = 5;   // offset + set bits <= 18
	localparam int KCNT_W    = 5;   // way count up to 16
	localparam int WAY_OUT_W = 3;

	// clamped configuration
	typedef struct packed {
		logic [CFG_DATA_W-1:0] offset;
		logic [CFG_DATA_W-1:0] setb;
		logic [KCNT_W-1:0]     ways;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic split;
		logic index;
		logic rd;
		logic upd;
		logic clr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT,
		ST_INDEX,
		ST_READ,
		ST_UPDATE
	} state_t;

endpackage

@@ rtl/salc_cfg.sv @@
// ----------------------------------------------------------------------------
// salc_cfg
// configuration registers with range clamping
// ----------------------------------------------------------------------------
module salc_cfg #(
	parameter int MAX_WAYS = salc_pkg::DEF_MAX_WAYS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
	output salc_pkg::cfg_t                  cfg
);

	logic [salc_pkg::CFG_DATA_W-1:0] offset_q;
	logic [salc_pkg::CFG_DATA_W-1:0] setb_q;
	logic [salc_pkg::CFG_DATA_W-1:0] ways_q;
	logic [salc_pkg::KCNT_W-1:0]     ways_ext;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= salc_pkg::RST_OFFSET_BITS;
			setb_q   <= salc_pkg::RST_SET_BITS;
			ways_q   <= salc_pkg::RST_WAYS_IN_USE;
		end else if (cfg_valid) begin
			case (cfg_index)
				salc_pkg::CFG_OFFSET_BITS: offset_q <= cfg_data;
				salc_pkg::CFG_SET_BITS:    setb_q   <= cfg_data;
				salc_pkg::CFG_WAYS_IN_USE: ways_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp to the supported ranges
	assign ways_ext = salc_pkg::KCNT_W'(ways_q);

	always_comb begin
		cfg.offset = (offset_q > salc_pkg::OFFSET_MAX) ? salc_pkg::OFFSET_MAX : offset_q;
		cfg.setb   = (setb_q > salc_pkg::SET_BITS_MAX) ? salc_pkg::SET_BITS_MAX : setb_q;
		if (ways_ext == '0) begin
			cfg.ways = salc_pkg::KCNT_W'(1);
		end else if (ways_ext > salc_pkg::KCNT_W'(MAX_WAYS)) begin
			cfg.ways = salc_pkg::KCNT_W'(MAX_WAYS);
		end else begin
			cfg.ways = ways_ext;
		end
	end

endmodule

@@ rtl/salc_ctrl.sv @@
// ----------------------------------------------------------------------------
// salc_ctrl
// sequencer: clearing pass, then split, index, read and update per access
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module salc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  salc_pkg::status_t status,
	output logic              busy,
	output salc_pkg::cmd_t    cmd
);

	salc_pkg::state_t state_q;
	salc_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			salc_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = salc_pkg::ST_IDLE;
				end
			end
			salc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = salc_pkg::ST_SPLIT;
				end
			end
			salc_pkg::ST_SPLIT: begin
				cmd.split = 1'b1;
				state_d   = salc_pkg::ST_INDEX;
			end
			salc_pkg::ST_INDEX: begin
				cmd.index = 1'b1;
				state_d   = salc_pkg::ST_READ;
			end
			salc_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = salc_pkg::ST_UPDATE;
			end
			salc_pkg::ST_UPDATE: begin
				cmd.upd = 1'b1;
				state_d = salc_pkg::ST_IDLE;
			end
			default: begin
				state_d = salc_pkg::ST_IDLE;
			end
		endcase
	end

	// checks
	`SALC_ASSERT(a_cmd_onehot0, $onehot0({cmd.load, cmd.split, cmd.index, cmd.rd, cmd.upd, cmd.clr}), "more than one command")
	`SALC_ASSERT(a_upd_then_idle, cmd.upd |=> !busy, "not ready after update")
	`SALC_ASSERT(a_step_order, cmd.split |=> cmd.index ##1 cmd.rd ##1 cmd.upd, "access steps out of order")
	`SALC_ASSERT_RST(a_no_load_in_reset, !arst_n |-> !cmd.load, "transfer taken during reset")

endmodule

@@ rtl/salc_dp.sv @@
// ----------------------------------------------------------------------------
// salc_dp
// address split, set index modulo, set row memory and lru update
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module salc_dp #(
	parameter int MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
	parameter int MAX_SETS   = salc_pkg::DEF_MAX_SETS,
	parameter int ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  salc_pkg::cmd_t                 cmd,
	input  salc_pkg::cfg_t                 cfg,
	input  logic [ADDR_WIDTH-1:0]          address,
	output salc_pkg::status_t              status,
	output logic                           done,
	output logic                           hit,
	output logic [salc_pkg::WAY_OUT_W-1:0] way
);

	localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int AGE_W     = WAY_IDX_W;
	localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int RS_W      = salc_pkg::RAW_SET_W;
	// reciprocal of the set count, exact for every raw index below 2**RS_W
	localparam int SH        = RS_W + $clog2(MAX_SETS);
	localparam int RECIP_W   = SH + 1;
	localparam int PROD_W    = RS_W + RECIP_W;
	localparam longint unsigned RECIP =
		((longint'(1) << SH) + longint'(MAX_SETS) - 1) / longint'(MAX_SETS);
	localparam logic [RS_W-1:0]  D_LO    = RS_W'(MAX_SETS);
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

	typedef struct packed {
		logic [MAX_WAYS-1:0]                 valid;
		logic [MAX_WAYS-1:0][AGE_W-1:0]      age;
		logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
	} row_t;

	row_t                  row_mem_q [MAX_SETS];
	row_t                  rd_row_q;
	row_t                  new_row;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [RS_W-1:0]       raw_q;
	logic [RS_W-1:0]       quo_q;
	logic [SET_W-1:0]      set_q;
	logic [SET_W-1:0]      clr_cnt_q;
	logic                  done_q;
	logic                  hit_q;
	logic [salc_pkg::WAY_OUT_W-1:0] way_q;

	logic [salc_pkg::SHIFT_W-1:0] shamt;
	logic [RS_W:0]         one_sh;
	logic [RS_W-1:0]       smask;
	logic [RS_W-1:0]       raw_set;
	logic [PROD_W-1:0]     prod;

	logic [MAX_WAYS-1:0]   inuse;
	logic [MAX_WAYS-1:0]   match;
	logic [MAX_WAYS-1:0]   free;
	logic [MAX_WAYS-1:0]   old_sel;
	logic                  found;
	logic                  have_free;
	logic [WAY_IDX_W-1:0]  hit_idx;
	logic [WAY_IDX_W-1:0]  free_idx;
	logic [WAY_IDX_W-1:0]  old_idx;
	logic [WAY_IDX_W-1:0]  chosen;
	logic [AGE_W-1:0]      mine;

	// address capture on a start transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= address;
		end
	end

	// split: tag, raw set index and reciprocal quotient
	assign shamt   = salc_pkg::SHIFT_W'(cfg.offset) + salc_pkg::SHIFT_W'(cfg.setb);
	assign one_sh  = (RS_W + 1)'(1) << cfg.setb;
	assign smask   = RS_W'(one_sh - (RS_W + 1)'(1));
	assign raw_set = RS_W'(addr_q >> cfg.offset) & smask;
	assign prod    = PROD_W'(raw_set) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.split) begin
			tag_q <= addr_q >> shamt;
			raw_q <= raw_set;
			quo_q <= RS_W'(prod >> SH);
		end
	end

	// set index = raw modulo the set count
	always_ff @(posedge clk) begin
		if (cmd.index) begin
			set_q <= SET_W'(raw_q - RS_W'(quo_q * D_LO));
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + SET_W'(1);
		end
	end

	assign status.clr_last = (clr_cnt_q == SET_W'(MAX_SETS - 1));

	// set row memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			row_mem_q[clr_cnt_q] <= '0;
		end else if (cmd.upd) begin
			row_mem_q[set_q] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_row_q <= row_mem_q[set_q];
		end
	end

	// per-way lookup flags
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			inuse[w] = (salc_pkg::KCNT_W'(w) < cfg.ways);
			match[w] = inuse[w] && rd_row_q.valid[w] && (rd_row_q.tag[w] == tag_q);
			free[w]  = inuse[w] && !rd_row_q.valid[w];
		end
	end

	// victim: greatest age, lowest way on a tie
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			old_sel[w] = inuse[w];
			for (int j = 0; j < MAX_WAYS; j++) begin
				if (inuse[j] && (j < w) && !(rd_row_q.age[w] > rd_row_q.age[j])) begin
					old_sel[w] = 1'b0;
				end
				if (inuse[j] && (j > w) && (rd_row_q.age[w] < rd_row_q.age[j])) begin
					old_sel[w] = 1'b0;
				end
			end
		end
	end

	// priority encoders
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		old_idx  = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_idx = WAY_IDX_W'(w);
			end
			if (free[w]) begin
				free_idx = WAY_IDX_W'(w);
			end
			if (old_sel[w]) begin
				old_idx = WAY_IDX_W'(w);
			end
		end
	end

	assign found     = |match;
	assign have_free = |free;
	assign chosen    = found ? hit_idx : (have_free ? free_idx : old_idx);
	assign mine      = rd_row_q.age[chosen];

	// new row: chosen way youngest, others age as the access demands
	always_comb begin
		new_row = rd_row_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_IDX_W'(w) == chosen) begin
				new_row.age[w] = '0;
				if (!found) begin
					new_row.tag[w]   = tag_q;
					new_row.valid[w] = 1'b1;
				end
			end else if (inuse[w] && rd_row_q.valid[w] &&
				(!found || (rd_row_q.age[w] < mine)) &&
				(rd_row_q.age[w] < AGE_MAX)) begin
				new_row.age[w] = rd_row_q.age[w] + AGE_W'(1);
			end
		end
	end

	// result register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.upd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			hit_q <= found;
			way_q <= salc_pkg::WAY_OUT_W'(chosen);
		end
	end

	assign done = done_q;
	assign hit  = hit_q;
	assign way  = way_q;

	// checks
	`SALC_ASSERT(a_done_one_cycle, done_q |=> !done_q, "result strobe longer than one cycle")
	`SALC_ASSERT(a_set_in_range, cmd.rd |-> (int'(set_q) < MAX_SETS), "set index out of range")
	`SALC_ASSERT(a_victim_onehot, (cmd.upd && !found && !have_free) |-> $onehot(old_sel), "victim select not one-hot")

endmodule

@@ rtl/set_assoc_lru_cache_lookup.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// set associative cache tag lookup with true lru replacement
//
//   channel   signals                                  direction
//   command   start, busy, address                     in (busy out)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//   result    done, hit, way                           out
//
// an access steps through accept, split, index
// (reciprocal modulo), set row read, update and write back.
// the result strobe comes the cycle after the update, together with the
// next possible accept; the receiver cannot stall results.
// after reset a clearing pass zeroes the set rows, busy is high meanwhile;
// config transfers are taken at any time.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup #(
	parameter int MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
	parameter int MAX_SETS   = salc_pkg::DEF_MAX_SETS,
	parameter int ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ADDR_WIDTH-1:0]           address,
	output logic                            done,
	output logic                            hit,
	output logic [salc_pkg::WAY_OUT_W-1:0]  way,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data
);

	salc_pkg::cfg_t    cfg;
	salc_pkg::cmd_t    cmd;
	salc_pkg::status_t status;

	// configuration registers
	salc_cfg #(
		.MAX_WAYS (MAX_WAYS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	salc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath and set memory
	salc_dp #(
		.MAX_WAYS   (MAX_WAYS),
		.MAX_SETS   (MAX_SETS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cfg     (cfg),
		.address (address),
		.status  (status),
		.done    (done),
		.hit     (hit),
		.way     (way)
	);

endmodule

@@ bench/set_assoc_lru_cache_lookup_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_tb
// self-checking bench for the set associative lru cache lookup
//
// a queue of planned lookups and register writes, filled at time zero, feeds
// a clocked driver. each accepted lookup runs through a mirror of the tag,
// valid and age arrays that computes the expected hit and way. a clocked
// monitor compares every result strobe with the oldest expected lookup.
// a directed part covers the clamping of all three registers, fills,
// hits, lru replacement, duplicate tags and age ties; random phases follow,
// each with its own register setting and a small working set of tags and
// sets so that hits and replacements are frequent.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_tb;

	localparam int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS;
	localparam int MAX_SETS     = salc_pkg::DEF_MAX_SETS;
	localparam int IDX_W        = salc_pkg::CFG_IDX_W;
	localparam int DATA_W       = salc_pkg::CFG_DATA_W;
	localparam int WAY_W        = salc_pkg::WAY_OUT_W;
	localparam int RANDOM_ITEMS = 1850;
	localparam int CFG_SETTLE   = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT_CYCLES = 1000000;

	// index with no register behind it
	localparam logic [IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	typedef enum logic {OP_LOOKUP, OP_CFG_WRITE} op_kind_t;

	typedef struct {
		op_kind_t          kind;
		logic [31:0]       addr;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
		int unsigned       gap;
	} plan_item_t;

	typedef struct {
		logic             hit;
		logic [WAY_W-1:0] way;
	} lookup_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [31:0]       address = '0;
	logic              done;
	logic              hit;
	logic [WAY_W-1:0]  way;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	plan_item_t     access_plan[$];
	lookup_result_t expected_lookups[$];
	int unsigned    error_count = 0;
	int unsigned    cycle_count = 0;

	// mirror of the cache state and registers
	logic [31:0]       mirror_tag   [MAX_SETS][MAX_WAYS];
	logic              mirror_valid [MAX_SETS][MAX_WAYS];
	logic [2:0]        mirror_age   [MAX_SETS][MAX_WAYS];
	logic [DATA_W-1:0] mirror_offset = salc_pkg::RST_OFFSET_BITS;
	logic [DATA_W-1:0] mirror_setb   = salc_pkg::RST_SET_BITS;
	logic [DATA_W-1:0] mirror_ways   = salc_pkg::RST_WAYS_IN_USE;

	set_assoc_lru_cache_lookup u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.address   (address),
		.done      (done),
		.hit       (hit),
		.way       (way),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// effective field widths and way count after clamping
	function automatic int unsigned eff_offset(input logic [DATA_W-1:0] raw);
		return 32'((raw > salc_pkg::OFFSET_MAX) ? salc_pkg::OFFSET_MAX : raw);
	endfunction

	function automatic int unsigned eff_set_bits(input logic [DATA_W-1:0] raw);
		return 32'((raw > salc_pkg::SET_BITS_MAX) ? salc_pkg::SET_BITS_MAX : raw);
	endfunction

	function automatic int unsigned eff_ways(input logic [DATA_W-1:0] raw);
		if (raw == 0)
			return 1;
		return (raw > MAX_WAYS) ? MAX_WAYS : 32'(raw);
	endfunction

	// age by one, saturating at the oldest age
	function automatic logic [2:0] age_plus(input logic [2:0] a);
		return (a < 3'(MAX_WAYS - 1)) ? a + 3'd1 : a;
	endfunction

	// lookup against the mirror, update it, and queue the expected result
	function automatic void predict_lookup(input logic [31:0] addr);
		int unsigned    ob, sb, nways, set_idx, chosen;
		logic [31:0]    tag;
		logic           found, have_free;
		logic [2:0]     mine, oldest;
		lookup_result_t res;
		ob      = eff_offset(mirror_offset);
		sb      = eff_set_bits(mirror_setb);
		nways   = eff_ways(mirror_ways);
		set_idx = ((addr >> ob) & ((32'd1 << sb) - 32'd1)) % MAX_SETS;
		tag     = addr >> (ob + sb);
		found   = 1'b0;
		chosen  = 0;
		// lowest valid way holding the tag
		for (int w = 0; w < nways; w++)
			if (!found && mirror_valid[set_idx][w] && mirror_tag[set_idx][w] == tag) begin
				found  = 1'b1;
				chosen = w;
			end
		if (found) begin
			// only ways younger than the hit way get older
			mine = mirror_age[set_idx][chosen];
			for (int w = 0; w < nways; w++)
				if (w != chosen && mirror_valid[set_idx][w] && mirror_age[set_idx][w] < mine)
					mirror_age[set_idx][w] = age_plus(mirror_age[set_idx][w]);
			mirror_age[set_idx][chosen] = 3'd0;
		end else begin
			// lowest free way, else the oldest with the lowest way on a tie
			have_free = 1'b0;
			for (int w = 0; w < nways; w++)
				if (!have_free && !mirror_valid[set_idx][w]) begin
					have_free = 1'b1;
					chosen    = w;
				end
			if (!have_free) begin
				oldest = 3'd0;
				chosen = 0;
				for (int w = 0; w < nways; w++)
					if (mirror_age[set_idx][w] > oldest) begin
						oldest = mirror_age[set_idx][w];
						chosen = w;
					end
			end
			for (int w = 0; w < nways; w++)
				if (w != chosen && mirror_valid[set_idx][w])
					mirror_age[set_idx][w] = age_plus(mirror_age[set_idx][w]);
			mirror_tag[set_idx][chosen]   = tag;
			mirror_valid[set_idx][chosen] = 1'b1;
			mirror_age[set_idx][chosen]   = 3'd0;
		end
		res.hit = found;
		res.way = chosen[WAY_W-1:0];
		expected_lookups.push_back(res);
	endfunction

	function automatic void apply_cfg(input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] data);
		case (idx)
			salc_pkg::CFG_OFFSET_BITS: mirror_offset = data;
			salc_pkg::CFG_SET_BITS:    mirror_setb   = data;
			salc_pkg::CFG_WAYS_IN_USE: mirror_ways   = data;
			default: ;
		endcase
	endfunction

	// idle gap ahead of a lookup: mostly short, a few long
	function automatic int unsigned draw_gap(input logic quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_lookup(input logic [31:0] addr, input logic quiet);
		plan_item_t item;
		item.kind = OP_LOOKUP;
		item.addr = addr;
		item.idx  = '0;
		item.data = '0;
		item.gap  = draw_gap(quiet);
		access_plan.push_back(item);
	endtask

	task automatic queue_cfg(input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] data);
		plan_item_t item;
		item.kind = OP_CFG_WRITE;
		item.addr = '0;
		item.idx  = idx;
		item.data = data;
		item.gap  = $urandom_range(0, 3);
		access_plan.push_back(item);
	endtask

	// driver: lookups and register writes from the plan
	int unsigned gap_left;
	logic        gap_armed;
	int unsigned idle_cycles;

	always @(posedge clk or negedge arst_n) begin
		logic       next_start, next_cfg_valid;
		plan_item_t item;
		if (!arst_n) begin
			start       <= 1'b0;
			address     <= '0;
			cfg_valid   <= 1'b0;
			cfg_index   <= '0;
			cfg_data    <= '0;
			gap_left    = 0;
			gap_armed   = 1'b0;
			idle_cycles = 0;
		end else begin
			next_start     = start;
			next_cfg_valid = cfg_valid;
			// lookup transfer
			if (start && !busy) begin
				predict_lookup(address);
				next_start = 1'b0;
			end
			// register write transfer
			if (cfg_valid && cfg_ready) begin
				apply_cfg(cfg_index, cfg_data);
				next_cfg_valid = 1'b0;
			end
			// quiet time since the last result
			if (expected_lookups.size() == 0 && !start)
				idle_cycles++;
			else
				idle_cycles = 0;
			// next planned item once the channel is free
			if (!next_start && !next_cfg_valid && access_plan.size() != 0) begin
				item = access_plan[0];
				if (!gap_armed) begin
					gap_left  = item.gap;
					gap_armed = 1'b1;
				end
				if (gap_left != 0) begin
					gap_left--;
				end else if (item.kind == OP_LOOKUP) begin
					void'(access_plan.pop_front());
					address    <= item.addr;
					next_start = 1'b1;
					gap_armed  = 1'b0;
				end else if (idle_cycles >= CFG_SETTLE) begin
					void'(access_plan.pop_front());
					cfg_index      <= item.idx;
					cfg_data       <= item.data;
					next_cfg_valid = 1'b1;
					gap_armed      = 1'b0;
				end
			end
			start     <= next_start;
			cfg_valid <= next_cfg_valid;
		end
	end

	// monitor: compare each result with the oldest expected lookup
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && done) begin
			if (expected_lookups.size() == 0) begin
				$error("unexpected result: hit %0d way %0d", hit, way);
				error_count++;
			end else begin
				want = expected_lookups.pop_front();
				if (hit !== want.hit) begin
					$error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
					error_count++;
				end
				if (way !== want.way) begin
					$error("way mismatch: expected %0d, actual %0d", want.way, way);
					error_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// plan, reset, drain and report
	initial begin
		logic [DATA_W-1:0] plan_offset, plan_setb, plan_ways;
		logic [31:0]       tag_pool[16];
		logic [31:0]       set_pool[4];
		logic [31:0]       addr, set_mask, off_mask;
		int unsigned       n_planned, phase_len, n_tags, n_sets, ob, sb, r;
		logic              quiet, wrote;

		for (int s = 0; s < MAX_SETS; s++)
			for (int w = 0; w < MAX_WAYS; w++)
				mirror_valid[s][w] = 1'b0;

		// directed: reset setting, fills, hits and lru replacement in set 0
		queue_lookup(32'h0000_0000, 1'b0);
		queue_lookup(32'h0000_0000, 1'b0);
		queue_lookup(32'hFFFF_FFFF, 1'b0);
		queue_lookup(32'hFFFF_FFFF, 1'b0);
		queue_lookup(32'h0000_1000, 1'b0);
		queue_lookup(32'h0000_2000, 1'b0);
		queue_lookup(32'h0000_3000, 1'b0);
		queue_lookup(32'h0000_4000, 1'b0);
		queue_lookup(32'h0000_2010, 1'b0);
		queue_lookup(32'h0000_5000, 1'b0);
		// all registers above their limits, plus the unmapped index
		queue_cfg(salc_pkg::CFG_OFFSET_BITS, 4'hF);
		queue_cfg(salc_pkg::CFG_SET_BITS, 4'hF);
		queue_cfg(salc_pkg::CFG_WAYS_IN_USE, 4'hF);
		queue_cfg(CFG_UNMAPPED, 4'hF);
		queue_lookup(32'hFFFF_FFFF, 1'b1);
		queue_lookup(32'h8000_0000, 1'b1);
		queue_lookup(32'hFFFF_FFFF, 1'b1);
		// duplicate tags and an age tie in a fresh set
		queue_cfg(salc_pkg::CFG_OFFSET_BITS, 4'd4);
		queue_cfg(salc_pkg::CFG_SET_BITS, 4'd1);
		queue_cfg(salc_pkg::CFG_WAYS_IN_USE, 4'd2);
		queue_lookup(32'h0000_0010, 1'b0);
		queue_lookup(32'h0000_0030, 1'b0);
		queue_cfg(salc_pkg::CFG_WAYS_IN_USE, 4'd0);
		queue_lookup(32'h0000_0030, 1'b0);
		queue_cfg(salc_pkg::CFG_WAYS_IN_USE, 4'd2);
		queue_lookup(32'h0000_0030, 1'b0);
		queue_lookup(32'h0000_0010, 1'b0);
		// zero offset and set widths with all ways
		queue_cfg(salc_pkg::CFG_OFFSET_BITS, 4'd0);
		queue_cfg(salc_pkg::CFG_SET_BITS, 4'd0);
		queue_cfg(salc_pkg::CFG_WAYS_IN_USE, 4'd8);
		queue_lookup(32'h0000_0000, 1'b0);
		queue_lookup(32'hFFFF_FFFF, 1'b0);
		plan_offset = 4'd0;
		plan_setb   = 4'd0;
		plan_ways   = 4'd8;

		// random phases, each with a new setting and a small working set
		n_planned = 0;
		while (n_planned < RANDOM_ITEMS) begin
			wrote = 1'b0;
			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					plan_offset = 4'($urandom_range(9, 15));
				else if (r == 1)
					plan_offset = 4'd0;
				else if (r == 2)
					plan_offset = salc_pkg::OFFSET_MAX;
				else
					plan_offset = 4'($urandom_range(0, 8));
				queue_cfg(salc_pkg::CFG_OFFSET_BITS, plan_offset);
				wrote = 1'b1;
			end
			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					plan_setb = 4'($urandom_range(11, 15));
				else if (r == 1)
					plan_setb = salc_pkg::SET_BITS_MAX;
				else if (r == 2)
					plan_setb = 4'd0;
				else
					plan_setb = 4'($urandom_range(0, 5));
				queue_cfg(salc_pkg::CFG_SET_BITS, plan_setb);
				wrote = 1'b1;
			end
			if (!wrote || $urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					plan_ways = 4'd0;
				else if (r == 1)
					plan_ways = 4'($urandom_range(9, 15));
				else
					plan_ways = 4'($urandom_range(1, 8));
				queue_cfg(salc_pkg::CFG_WAYS_IN_USE, plan_ways);
			end
			if ($urandom_range(0, 9) == 0)
				queue_cfg(CFG_UNMAPPED, 4'($urandom_range(0, 15)));

			ob       = eff_offset(plan_offset);
			sb       = eff_set_bits(plan_setb);
			set_mask = (32'd1 << sb) - 32'd1;
			off_mask = (32'd1 << ob) - 32'd1;
			n_tags   = eff_ways(plan_ways) + $urandom_range(0, 3);
			n_sets   = $urandom_range(1, 3);
			for (int t = 0; t < n_tags; t++)
				tag_pool[t] = $urandom;
			for (int t = 0; t < n_sets; t++)
				set_pool[t] = $urandom;
			quiet     = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(40, 160);

			// mostly working-set addresses, some fully random
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(0, 4) == 0)
					addr = $urandom;
				else
					addr = (tag_pool[$urandom_range(0, n_tags - 1)] << (ob + sb))
						| ((set_pool[$urandom_range(0, n_sets - 1)] & set_mask) << ob)
						| ($urandom & off_mask);
				queue_lookup(addr, quiet);
			end
			n_planned += phase_len;
		end

		// single reset at the start
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// drain: all planned items sent and every result seen
		while (access_plan.size() != 0 || expected_lookups.size() != 0 || start || cfg_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_lookups.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
